[hdl/rotary_position_rotate_assert.svh]
// ----------------------------------------------------------------------------
// rotary position rotate assertion macros
// concurrent checks on clk, disabled while arst_n is low
// ----------------------------------------------------------------------------
`ifndef ROTARY_POSITION_ROTATE_ASSERT_SVH
`define ROTARY_POSITION_ROTATE_ASSERT_SVH
`ifndef SYNTHESIS
`define RPR_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rotary position rotate check failed");
`define RPR_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rotary position rotate check failed");
`else
`define RPR_ASSERT_IMPL(lbl, ante, cons)
`define RPR_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

[hdl/rpr_pkg.sv]
// ----------------------------------------------------------------------------
// rotary position rotate package
// shared types, register codes and fixed-point constants
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package rpr_pkg;
	typedef logic signed [15:0] elem_t;
	typedef logic [15:0] pos_t;
	typedef logic [6:0] pidx_t;

	typedef enum logic [1:0] {
		REG_MODE      = 2'd0,
		REG_HEAD_DIM  = 2'd1,
		REG_BASE_LOG2 = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		elem_t xe;
		elem_t xo;
		pos_t  pos;
		logic  byp;
	} side_t;

	// 2^(-2^-k) in q0.31, k = 1..16
	localparam logic [30:0] EXP_TAB [16] = '{
		31'd1518500250, 31'd1805811302, 31'd1969251188, 31'd2056437387,
		31'd2101467502, 31'd2124350983, 31'd2135885998, 31'd2141676973,
		31'd2144578345, 31'd2146030506, 31'd2146756953, 31'd2147120270,
		31'd2147301951, 31'd2147392798, 31'd2147438222, 31'd2147460935
	};

	localparam logic [29:0] TURN_PER_RAD = 30'd683565276;
	localparam logic [30:0] QUARTER      = 31'h4000_0000;
	localparam logic [30:0] C9           = 31'd172272;
	// horner coefficients in order of use
	localparam logic [30:0] HORNER_C [4] = '{
		31'd5026995, 31'd85569306, 31'd693598669, 31'd1686629713
	};

	function automatic elem_t round_sat(input logic signed [32:0] v);
		logic signed [33:0] s;
		logic signed [19:0] r;
		s = 34'(v) + 34'sd8192;
		r = 20'(s >>> 14);
		if (r > 20'sd32767)
			round_sat = 16'sh7fff;
		else if (r < -20'sd32768)
			round_sat = 16'sh8000;
		else
			round_sat = r[15:0];
	endfunction
endpackage

[hdl/rpr_in_if.sv]
// ----------------------------------------------------------------------------
// rpr input channel
// one element pair with its position and pair index per beat
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
interface rpr_in_if;
	import rpr_pkg::*;
	logic  valid;
	logic  ready;
	elem_t x_even;
	elem_t x_odd;
	pos_t  position;
	pidx_t pair_index;
	modport source (output valid, x_even, x_odd, position, pair_index, input ready);
	modport sink (input valid, x_even, x_odd, position, pair_index, output ready);
endinterface

[hdl/rpr_out_if.sv]
// ----------------------------------------------------------------------------
// rpr output channel
// one rotated element pair per beat
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
interface rpr_out_if;
	import rpr_pkg::*;
	logic  valid;
	logic  ready;
	elem_t y_even;
	elem_t y_odd;
	modport source (output valid, y_even, y_odd, input ready);
	modport sink (input valid, y_even, y_odd, output ready);
endinterface

[hdl/rotary_position_rotate.sv]
// ----------------------------------------------------------------------------
// rotary position rotate
// 51 stages from input beat to output beat
// throughput one pair per cycle unless the output stalls; a stalled cell holds its beat
// stages: input, 22 divider, 16 exponent, 4 phase, 4 horner, 4 output cells
// arst_n clears the stage valid bits and loads the register defaults
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "rotary_position_rotate_assert.svh"
module rotary_position_rotate #(
	parameter int MAX_HEAD_DIM  = 256,
	parameter int POSITION_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	rpr_in_if.sink      pair_in,
	rpr_out_if.source   pair_out
);
	import rpr_pkg::*;

	localparam int NS = 51;
	localparam int SD = 1;
	localparam int SE = 23;
	localparam int SW1 = 39;
	localparam int SW2 = 40;
	localparam int SP = 41;
	localparam int SX = 42;
	localparam int SH = 43;
	localparam int SS = 47;
	localparam int ST = 48;
	localparam int SR = 49;
	localparam int SO = 50;
	localparam logic [8:0] HD_CLAMP = (MAX_HEAD_DIM > 511) ? 9'd511 : 9'(MAX_HEAD_DIM);
	localparam logic [15:0] POS_MASK =
		(POSITION_BITS >= 16) ? 16'hffff : 16'((1 << POSITION_BITS) - 1);

	// registers
	logic        mode_q;
	logic [8:0]  hdim_q;
	logic [21:0] base_log2_q;
	cfg_idx_t    widx;
	cfg_idx_t    ridx;

	assign pready = 1'b1;
	assign widx   = cfg_idx_t'(paddr[3:2]);
	assign ridx   = cfg_idx_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= 1'b0;
			hdim_q      <= 9'd64;
			base_log2_q <= 22'd870828;
		end else if (psel && penable && pwrite && pready) begin
			case (widx)
				REG_MODE:      mode_q      <= pwdata[0];
				REG_HEAD_DIM:  hdim_q      <= pwdata[8:0];
				REG_BASE_LOG2: base_log2_q <= pwdata[21:0];
				default:       ;
			endcase
		end
	end

	always_comb begin
		case (ridx)
			REG_MODE:      prdata = {31'd0, mode_q};
			REG_HEAD_DIM:  prdata = {23'd0, hdim_q};
			REG_BASE_LOG2: prdata = {10'd0, base_log2_q};
			default:       prdata = 32'd0;
		endcase
	end

	// flow control
	logic [NS-1:0] v_q;
	logic [NS-1:0] en;
	side_t         side_q [NS];

	assign en[NS-1] = !v_q[NS-1] || pair_out.ready;
	for (genvar i = 0; i < NS - 1; i++) begin : g_en
		assign en[i] = !v_q[i] || en[i+1];
	end
	assign pair_in.ready = en[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (en[0])
				v_q[0] <= pair_in.valid;
			for (int i = 1; i < NS; i++)
				if (en[i])
					v_q[i] <= v_q[i-1];
		end
	end

	// input stage
	logic [8:0]  hd;
	side_t       side_in;
	logic [29:0] num_s1;

	assign hd          = (hdim_q > HD_CLAMP) ? HD_CLAMP : hdim_q;
	assign side_in.xe  = pair_in.x_even;
	assign side_in.xo  = pair_in.x_odd;
	assign side_in.pos = pair_in.position & POS_MASK;
	assign side_in.byp = mode_q || ({1'b0, pair_in.pair_index, 1'b1} >= hd);

	always_ff @(posedge clk) begin
		if (en[0]) begin
			side_q[0] <= side_in;
			num_s1    <= base_log2_q * {pair_in.pair_index, 1'b0};
		end
		for (int i = 1; i < NS; i++)
			if (en[i])
				side_q[i] <= side_q[i-1];
	end

	// exponent divider
	logic [8:0]  rem_d [23];
	logic [21:0] wq_d  [23];

	assign rem_d[0] = {1'b0, num_s1[29:22]};
	assign wq_d[0]  = num_s1[21:0];
	for (genvar i = 0; i < 22; i++) begin : g_div
		rpr_div_cell u_div (
			.clk    (clk),
			.en     (en[SD+i]),
			.d      (hd),
			.rem_in (rem_d[i]),
			.wq_in  (wq_d[i]),
			.rem_q  (rem_d[i+1]),
			.wq_q   (wq_d[i+1])
		);
	end

	// 2^-f
	logic [21:0] e_e [17];
	logic [31:0] m_e [17];

	assign e_e[0] = wq_d[22];
	assign m_e[0] = 32'h8000_0000;
	for (genvar k = 0; k < 16; k++) begin : g_exp
		rpr_exp_cell #(.K(k)) u_exp (
			.clk  (clk),
			.en   (en[SE+k]),
			.e_in (e_e[k]),
			.m_in (m_e[k]),
			.e_q  (e_e[k+1]),
			.m_q  (m_e[k+1])
		);
	end

	// frequency and phase
	logic [61:0] wprod_s39;
	logic [5:0]  n_s39;
	logic [31:0] w_s40;
	logic [31:0] phase_s41;
	logic [6:0]  shamt;
	logic [61:0] wsh;
	logic [47:0] pprod;

	assign shamt = 7'd31 + {1'b0, n_s39};
	assign wsh   = wprod_s39 >> shamt;
	assign pprod = {32'd0, side_q[SW2].pos} * {16'd0, w_s40};

	always_ff @(posedge clk) begin
		if (en[SW1]) begin
			wprod_s39 <= {30'd0, m_e[16]} * {32'd0, TURN_PER_RAD};
			n_s39     <= e_e[16][21:16];
		end
		if (en[SW2])
			w_s40 <= (n_s39 > 6'd32) ? 32'd0 : wsh[31:0];
		if (en[SP])
			phase_s41 <= pprod[31:0];
	end

	// quarter-wave arguments and squares
	logic [30:0] xs;
	logic [30:0] xc;
	logic [61:0] xsq;
	logic [61:0] xcq;
	logic [30:0] xs_s42, xc_s42, x2s_s42, x2c_s42;
	logic [1:0]  quad_s42;

	assign xs  = {1'b0, phase_s41[29:0]};
	assign xc  = QUARTER - xs;
	assign xsq = {31'd0, xs} * {31'd0, xs};
	assign xcq = {31'd0, xc} * {31'd0, xc};

	always_ff @(posedge clk) begin
		if (en[SX]) begin
			xs_s42   <= xs;
			xc_s42   <= xc;
			x2s_s42  <= xsq[60:30];
			x2c_s42  <= xcq[60:30];
			quad_s42 <= phase_s41[31:30];
		end
	end

	// quadrant registers follow the horner cells
	logic [1:0] quad_h [4];
	always_ff @(posedge clk) begin
		if (en[SH])
			quad_h[0] <= quad_s42;
		for (int j = 1; j < 4; j++)
			if (en[SH+j])
				quad_h[j] <= quad_h[j-1];
	end

	logic [30:0] xs_h [5], x2s_h [5], ts_h [5];
	logic [30:0] xc_h [5], x2c_h [5], tc_h [5];

	assign xs_h[0]  = xs_s42;
	assign x2s_h[0] = x2s_s42;
	assign ts_h[0]  = C9;
	assign xc_h[0]  = xc_s42;
	assign x2c_h[0] = x2c_s42;
	assign tc_h[0]  = C9;
	for (genvar j = 0; j < 4; j++) begin : g_poly
		rpr_poly_cell #(.C(HORNER_C[j])) u_sin (
			.clk   (clk),
			.en    (en[SH+j]),
			.x_in  (xs_h[j]),
			.x2_in (x2s_h[j]),
			.t_in  (ts_h[j]),
			.x_q   (xs_h[j+1]),
			.x2_q  (x2s_h[j+1]),
			.t_q   (ts_h[j+1])
		);
		rpr_poly_cell #(.C(HORNER_C[j])) u_cos (
			.clk   (clk),
			.en    (en[SH+j]),
			.x_in  (xc_h[j]),
			.x2_in (x2c_h[j]),
			.t_in  (tc_h[j]),
			.x_q   (xc_h[j+1]),
			.x2_q  (x2c_h[j+1]),
			.t_q   (tc_h[j+1])
		);
	end

	// final multiply, rounding and quadrant fold
	logic [61:0]        sprod, cprod;
	logic [31:0]        s_s47, c_s47;
	logic [1:0]         quad_s47;
	logic [32:0]        srnd, crnd;
	logic [14:0]        sa, ca;
	logic signed [15:0] sas, cas;
	logic signed [15:0] sn_s48, cs_s48;

	assign sprod = {31'd0, xs_h[4]} * {31'd0, ts_h[4]};
	assign cprod = {31'd0, xc_h[4]} * {31'd0, tc_h[4]};
	assign srnd  = {1'b0, s_s47} + 33'd32768;
	assign crnd  = {1'b0, c_s47} + 33'd32768;
	assign sa    = (srnd[32:16] > 17'd16384) ? 15'd16384 : srnd[30:16];
	assign ca    = (crnd[32:16] > 17'd16384) ? 15'd16384 : crnd[30:16];
	assign sas   = $signed({1'b0, sa});
	assign cas   = $signed({1'b0, ca});

	always_ff @(posedge clk) begin
		if (en[SS]) begin
			s_s47    <= sprod[61:30];
			c_s47    <= cprod[61:30];
			quad_s47 <= quad_h[3];
		end
		if (en[ST]) begin
			case (quad_s47)
				2'd0: begin
					sn_s48 <= sas;
					cs_s48 <= cas;
				end
				2'd1: begin
					sn_s48 <= cas;
					cs_s48 <= -sas;
				end
				2'd2: begin
					sn_s48 <= -sas;
					cs_s48 <= -cas;
				end
				default: begin
					sn_s48 <= -cas;
					cs_s48 <= sas;
				end
			endcase
		end
	end

	// rotation
	logic signed [31:0] pec_s49, pos_s49, pes_s49, poc_s49;
	logic signed [32:0] ye, yo;
	elem_t              ye_s50, yo_s50;

	assign ye = 33'(pec_s49) - 33'(pos_s49);
	assign yo = 33'(pes_s49) + 33'(poc_s49);

	always_ff @(posedge clk) begin
		if (en[SR]) begin
			pec_s49 <= side_q[SR-1].xe * cs_s48;
			pos_s49 <= side_q[SR-1].xo * sn_s48;
			pes_s49 <= side_q[SR-1].xe * sn_s48;
			poc_s49 <= side_q[SR-1].xo * cs_s48;
		end
		if (en[SO]) begin
			ye_s50 <= side_q[SO-1].byp ? side_q[SO-1].xe : round_sat(ye);
			yo_s50 <= side_q[SO-1].byp ? side_q[SO-1].xo : round_sat(yo);
		end
	end

	assign pair_out.valid  = v_q[NS-1];
	assign pair_out.y_even = ye_s50;
	assign pair_out.y_odd  = yo_s50;

	`RPR_ASSERT_NEXT(a_accept_fills, pair_in.valid && pair_in.ready, v_q[0])
	`RPR_ASSERT_IMPL(a_empty_ready, !v_q[NS-1], pair_in.ready)
	`RPR_ASSERT_NEXT(a_bypass_even, en[NS-1] && v_q[NS-2] && side_q[NS-2].byp,
		pair_out.y_even == $past(side_q[NS-2].xe))
endmodule

[hdl/rpr_div_cell.sv]
// ----------------------------------------------------------------------------
// rpr divider cell
// one restoring quotient bit per cell of the exponent divider
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module rpr_div_cell (
	input  logic        clk,
	input  logic        en,
	input  logic [8:0]  d,
	input  logic [8:0]  rem_in,
	input  logic [21:0] wq_in,
	output logic [8:0]  rem_q,
	output logic [21:0] wq_q
);
	logic [9:0] t;
	logic [9:0] diff;
	logic       ge;

	assign t    = {rem_in, wq_in[21]};
	assign ge   = t >= {1'b0, d};
	assign diff = t - {1'b0, d};

	always_ff @(posedge clk) begin
		if (en) begin
			rem_q <= ge ? diff[8:0] : t[8:0];
			wq_q  <= {wq_in[20:0], ge};
		end
	end
endmodule

[hdl/rpr_exp_cell.sv]
// ----------------------------------------------------------------------------
// rpr exponent cell
// applies one factor of 2^-f for a single fraction bit
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module rpr_exp_cell #(
	parameter int K = 0
) (
	input  logic        clk,
	input  logic        en,
	input  logic [21:0] e_in,
	input  logic [31:0] m_in,
	output logic [21:0] e_q,
	output logic [31:0] m_q
);
	import rpr_pkg::*;

	logic [62:0] prod;
	logic [63:0] rnd;

	assign prod = {31'd0, m_in} * {32'd0, EXP_TAB[K]};
	assign rnd  = {1'b0, prod} + 64'h0000_0000_4000_0000;

	always_ff @(posedge clk) begin
		if (en) begin
			e_q <= e_in;
			m_q <= e_in[15-K] ? rnd[62:31] : m_in;
		end
	end
endmodule

[hdl/rpr_poly_cell.sv]
// ----------------------------------------------------------------------------
// rpr polynomial cell
// one horner step of the quarter-wave sine series
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module rpr_poly_cell #(
	parameter logic [30:0] C = 31'd0
) (
	input  logic        clk,
	input  logic        en,
	input  logic [30:0] x_in,
	input  logic [30:0] x2_in,
	input  logic [30:0] t_in,
	output logic [30:0] x_q,
	output logic [30:0] x2_q,
	output logic [30:0] t_q
);
	logic [61:0] prod;
	logic [31:0] t_n;

	assign prod = {31'd0, x2_in} * {31'd0, t_in};
	assign t_n  = {1'b0, C} - prod[61:30];

	always_ff @(posedge clk) begin
		if (en) begin
			x_q  <= x_in;
			x2_q <= x2_in;
			t_q  <= t_n[30:0];
		end
	end
endmodule

[verif/rotary_position_rotate_tb.sv]
// ----------------------------------------------------------------------------
// rotary position rotate testbench
// drives element pairs through the rotator and the register port, predicts
// each rotated pair in fixed point and checks every output beat in order
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module rotary_position_rotate_tb;
	import rpr_pkg::*;

	localparam int HOLD_CYCLES = 300;
	localparam int DRAIN_CYCLES = 60;
	localparam int STUCK_LIMIT = 3000;

	typedef struct {
		elem_t ye;
		elem_t yo;
	} pair_t;

	class rope_scoreboard;
		logic        mode;
		logic [8:0]  hdim;
		logic [21:0] base_log2;
		pair_t       rotated_q[$];
		int          errors;

		function void restore_defaults();
			mode = 1'b0;
			hdim = 9'd64;
			base_log2 = 22'd870828;
		endfunction

		function longint quarter_sin(longint unsigned x);
			longint unsigned x2, t, s;
			x2 = (x * x) >> 30;
			t = 64'd172272;
			t = 64'd5026995 - ((x2 * t) >> 30);
			t = 64'd85569306 - ((x2 * t) >> 30);
			t = 64'd693598669 - ((x2 * t) >> 30);
			t = 64'd1686629713 - ((x2 * t) >> 30);
			s = (x * t) >> 30;
			s = (s + 64'd32768) >> 16;
			if (s > 64'd16384)
				s = 64'd16384;
			return longint'(s);
		endfunction

		function elem_t clamp_q14(longint v);
			longint r;
			r = (v + 8192) >>> 14;
			if (r > 32767)
				r = 32767;
			if (r < -32768)
				r = -32768;
			return elem_t'(r[15:0]);
		endfunction

		function void note_pair(elem_t xe, elem_t xo, pos_t pos, pidx_t p);
			longint unsigned hd, e, n, f, m, w, phase, a;
			longint sa, ca, sn, cs, ve, vo;
			logic [1:0] quad;
			pair_t r;
			hd = (hdim > 9'd256) ? 64'd256 : 64'(hdim);
			if (mode || (2 * 64'(p) + 1 >= hd)) begin
				r.ye = xe;
				r.yo = xo;
			end else begin
				e = (64'(base_log2) * 2 * 64'(p)) / hd;
				n = e >> 16;
				f = e & 64'hffff;
				m = 64'd2147483648;
				for (int k = 0; k < 16; k++) begin
					if (f[15 - k])
						m = (m * 64'(EXP_TAB[k]) + 64'd1073741824) >> 31;
				end
				w = (n > 32) ? 64'd0 : (m * 64'd683565276) >> (31 + n);
				phase = (64'(pos) * w) & 64'hffff_ffff;
				quad = phase[31:30];
				a = phase & 64'h3fff_ffff;
				sa = quarter_sin(a);
				ca = quarter_sin(64'h4000_0000 - a);
				case (quad)
					2'd0: begin sn = sa; cs = ca; end
					2'd1: begin sn = ca; cs = -sa; end
					2'd2: begin sn = -sa; cs = -ca; end
					default: begin sn = -ca; cs = sa; end
				endcase
				ve = longint'(xe) * cs - longint'(xo) * sn;
				vo = longint'(xe) * sn + longint'(xo) * cs;
				r.ye = clamp_q14(ve);
				r.yo = clamp_q14(vo);
			end
			rotated_q.push_back(r);
		endfunction

		function void check_pair(elem_t ye, elem_t yo);
			pair_t r;
			if (rotated_q.size() == 0) begin
				$error("unexpected output beat y_even %0d y_odd %0d", ye, yo);
				errors++;
				return;
			end
			r = rotated_q.pop_front();
			if (ye !== r.ye) begin
				$error("y_even expected %0d actual %0d", r.ye, ye);
				errors++;
			end
			if (yo !== r.yo) begin
				$error("y_odd expected %0d actual %0d", r.yo, yo);
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        psel, penable, pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        quiet;
	int          in_beats;
	int          stuck;
	rope_scoreboard sb;

	rpr_in_if  pair_in_bus();
	rpr_out_if pair_out_bus();

	rotary_position_rotate i_dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.pair_in(pair_in_bus), .pair_out(pair_out_bus)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// beat monitors
	always @(posedge clk) begin
		if (arst_n && pair_in_bus.valid && pair_in_bus.ready) begin
			sb.note_pair(pair_in_bus.x_even, pair_in_bus.x_odd,
				pair_in_bus.position, pair_in_bus.pair_index);
			in_beats++;
		end
		if (arst_n && pair_out_bus.valid && pair_out_bus.ready)
			sb.check_pair(pair_out_bus.y_even, pair_out_bus.y_odd);
	end

	// watchdog on cycles without any beat or register access
	always @(posedge clk) begin
		if ((pair_in_bus.valid && pair_in_bus.ready) ||
				(pair_out_bus.valid && pair_out_bus.ready) || psel)
			stuck <= 0;
		else
			stuck <= stuck + 1;
		if (stuck >= STUCK_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// receiver, with one long hold-off so the pipe fills
	initial begin
		bit held;
		held = 0;
		pair_out_bus.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!held && in_beats >= 400) begin
				held = 1;
				pair_out_bus.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			pair_out_bus.ready <= quiet ? 1'b1 : ($urandom_range(99) >= 28);
		end
	end

	task automatic reg_write(cfg_idx_t idx, logic [31:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= 4'(idx) << 2;
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		case (idx)
			REG_MODE: sb.mode = val[0];
			REG_HEAD_DIM: sb.hdim = val[8:0];
			default: sb.base_log2 = val[21:0];
		endcase
	endtask

	task automatic settle();
		while (sb.rotated_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic send_pair(elem_t xe, elem_t xo, pos_t pos, pidx_t p);
		pair_in_bus.valid <= 1'b1;
		pair_in_bus.x_even <= xe;
		pair_in_bus.x_odd <= xo;
		pair_in_bus.position <= pos;
		pair_in_bus.pair_index <= p;
		do @(posedge clk); while (!pair_in_bus.ready);
		if (!quiet && $urandom_range(99) < 28) begin
			pair_in_bus.valid <= 1'b0;
			repeat ($urandom_range(4, 1)) @(posedge clk);
		end
	endtask

	task automatic end_burst();
		pair_in_bus.valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic elem_t rand_elem();
		case ($urandom_range(9))
			0: return 16'sh7fff;
			1: return 16'sh8000;
			2: return 16'sh1000;
			default: return elem_t'($urandom);
		endcase
	endfunction

	task automatic random_pairs(int count);
		int half;
		pos_t pos;
		pidx_t p;
		half = (sb.hdim > 9'd256) ? 128 : sb.hdim / 2;
		for (int i = 0; i < count; i++) begin
			if (half > 0 && $urandom_range(99) < 85)
				p = pidx_t'($urandom_range(half - 1));
			else
				p = pidx_t'($urandom);
			case ($urandom_range(9))
				0: pos = 16'd0;
				1: pos = 16'hffff;
				default: pos = pos_t'($urandom);
			endcase
			send_pair(rand_elem(), rand_elem(), pos, p);
		end
		end_burst();
	endtask

	initial begin
		sb = new();
		sb.restore_defaults();
		quiet = 1'b0;
		in_beats = 0;
		stuck = 0;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		pair_in_bus.valid = 1'b0;
		pair_in_bus.x_even = '0;
		pair_in_bus.x_odd = '0;
		pair_in_bus.position = '0;
		pair_in_bus.pair_index = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed, reset settings
		send_pair(16'sh7fff, 16'sh7fff, 16'd1, 7'd0);
		send_pair(16'sh8000, 16'sh8000, 16'd1, 7'd1);
		send_pair(16'sh7fff, 16'sh8000, 16'hffff, 7'd1);
		send_pair(16'sh8000, 16'sh7fff, 16'd12345, 7'd5);
		send_pair(16'sh1000, 16'sh0000, 16'd3, 7'd0);
		send_pair(16'sh1000, 16'sh1000, 16'd0, 7'd31);
		send_pair(16'sh1234, 16'sh4321, 16'd77, 7'd32);
		send_pair(16'sh7fff, 16'sh7fff, 16'd500, 7'd127);
		end_burst();
		settle();

		// identity mode
		reg_write(REG_MODE, 32'd1);
		send_pair(16'sh7fff, 16'sh8000, 16'd100, 7'd3);
		send_pair(16'sh8000, 16'sh7fff, 16'hffff, 7'd0);
		end_burst();
		random_pairs(150);
		settle();
		reg_write(REG_MODE, 32'd0);

		// head dim above maximum is clamped, huge base gives zero angle at high pair indices
		reg_write(REG_HEAD_DIM, 32'd511);
		reg_write(REG_BASE_LOG2, 32'h3fffff);
		send_pair(16'sh4000, 16'sh2000, 16'hffff, 7'd127);
		send_pair(16'sh4000, 16'sh2000, 16'hffff, 7'd1);
		end_burst();
		random_pairs(200);
		settle();

		// head dim zero and one, every pair outside the head
		reg_write(REG_HEAD_DIM, 32'd0);
		send_pair(16'sh1111, 16'sh2222, 16'd9, 7'd0);
		end_burst();
		settle();
		reg_write(REG_HEAD_DIM, 32'd1);
		send_pair(16'sh3333, 16'sh4444, 16'd9, 7'd0);
		random_pairs(40);
		settle();

		// base zero: every pair turns at one radian per position
		reg_write(REG_HEAD_DIM, 32'd256);
		reg_write(REG_BASE_LOG2, 32'd0);
		random_pairs(200);
		settle();

		// no idling stretch
		quiet = 1'b1;
		reg_write(REG_HEAD_DIM, 32'd64);
		reg_write(REG_BASE_LOG2, 32'd870828);
		random_pairs(300);
		settle();
		quiet = 1'b0;

		// further random settings
		for (int ph = 0; ph < 4; ph++) begin
			reg_write(REG_HEAD_DIM, $urandom_range(256, 2));
			reg_write(REG_BASE_LOG2, $urandom_range(32'h3fffff));
			random_pairs(160);
			settle();
		end

		if (sb.rotated_q.size() != 0) begin
			$error("%0d expected pairs never arrived", sb.rotated_q.size());
			sb.errors++;
		end
		if (sb.errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end
endmodule
